[rtl/fcd_pkg.sv]
// Shared types and constants for the 16-point ring corner detector.
`timescale 1ns / 1ps
`default_nettype none

package fcd_pkg;

  // Default build parameters
  localparam int unsigned MAX_WIDTH_DEF      = 1024;
  localparam int unsigned GRAY_FRAC_BITS_DEF = 10;

  // Fixed geometry
  localparam int unsigned STORED_LINES = 6;
  localparam int unsigned WIN          = 7;
  localparam int unsigned RING_PTS     = 16;

  // Ring taps as window row / column (center at 3,3)
  localparam int unsigned RING_ROW [RING_PTS] =
    '{0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0};
  localparam int unsigned RING_COL [RING_PTS] =
    '{3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1, 2};

  localparam logic [7:0] CORNER_SHADE = 8'd120;

  // Register reset values
  localparam logic [7:0]  THRESHOLD_RST  = 8'd60;
  localparam logic [4:0]  MIN_COUNT_RST  = 5'd12;
  localparam logic [10:0] LINE_WIDTH_RST = 11'd640;

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_MIN_COUNT  = 2'd1,
    REG_LINE_WIDTH = 2'd2
  } cfg_reg_t;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef struct packed {
    logic [7:0] red_sample;
    logic [7:0] green_sample;
    logic [7:0] blue_sample;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic       corner;
    logic [7:0] shade;
    logic       row_end;
  } out_beat_t;

endpackage

`default_nettype wire

[rtl/fast_corner_detector_ring16.sv]
// Top level of the streaming 16-point ring corner detector.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_beat  (in_beat_t: RGB + frame_start)
// out_      output     out_valid / out_stall out_beat (out_beat_t: corner, shade, row_end)
// cfg       input      psel/penable/pready   threshold, min_count, line_width
//
// One pixel beat is taken per clock while in_stall is low. The line store is read at the
// accepting edge and the result passes the window shift, ring compare and count stages
// into the output register; the line store (one read, one write a cycle) sets the
// one-beat-per-clock figure. Reset clears the pipeline valids, column
// counter, row counter and registers; line store and window hold no reset.
// A stalled output lets the three inner stages keep filling before in_stall
// rises; border pixels drop out after the window stage and never reach out_.

module fast_corner_detector_ring16
  import fcd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int unsigned GRAY_FRAC_BITS = GRAY_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // pixel input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_beat_t              in_beat,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_beat_t                  out_beat,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  // Gray value width: 8-bit sample scaled by 2^GRAY_FRAC_BITS
  localparam int unsigned GW = 8 + GRAY_FRAC_BITS;
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int unsigned MW = STORED_LINES * GW;

  localparam int unsigned SCALE = 1 << GRAY_FRAC_BITS;
  localparam logic [GRAY_FRAC_BITS-1:0] WEIGHT_R =
    GRAY_FRAC_BITS'((299 * SCALE + 500) / 1000);
  localparam logic [GRAY_FRAC_BITS-1:0] WEIGHT_G =
    GRAY_FRAC_BITS'((587 * SCALE + 500) / 1000);
  localparam logic [GRAY_FRAC_BITS-1:0] WEIGHT_B =
    GRAY_FRAC_BITS'((114 * SCALE + 500) / 1000);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  threshold_r;
  logic [4:0]  min_count_r;
  logic [10:0] line_width_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      min_count_r  <= MIN_COUNT_RST;
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESHOLD:  threshold_r  <= pwdata[7:0];
        REG_MIN_COUNT:  min_count_r  <= pwdata[4:0];
        REG_LINE_WIDTH: line_width_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD:  prdata = {24'd0, threshold_r};
      REG_MIN_COUNT:  prdata = {27'd0, min_count_r};
      REG_LINE_WIDTH: prdata = {21'd0, line_width_r};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: s1 line store, s2 window compare, s3 count, output register
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic s1_prod_r, s2_prod_r;
  logic s1_last_r, s2_last_r, s3_last_r;
  logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, accept;

  assign out_free = !out_vld_r | !out_stall;
  assign s3_go    = s3_vld_r & out_free;
  assign s3_free  = !s3_vld_r | s3_go;
  // border pixels leave s2 without taking a slot downstream
  assign s2_go    = s2_vld_r & (!s2_prod_r | s3_free);
  assign s2_free  = !s2_vld_r | s2_go;
  assign s1_go    = s1_vld_r & s2_free;
  assign s1_free  = !s1_vld_r | s1_go;
  assign in_stall = !s1_free;
  assign accept   = in_valid & !in_stall;

  // ---------------------------------------------------------------------------
  // Stage 0: column / row tracking, gray conversion, line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [2:0]    rows_r, rows_nxt, rows_cur;
  logic [WW-1:0] width_eff, width_ext;
  logic          last_cur, prod_cur;
  logic [GW-1:0] gray_cur;

  always_comb begin
    width_ext = WW'(line_width_r);
    if (width_ext < WW'(WIN)) begin
      width_eff = WW'(WIN);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
  end

  always_comb begin
    // frame start restarts counting before the pixel is placed
    col_cur  = in_beat.frame_start ? '0 : col_r;
    rows_cur = in_beat.frame_start ? 3'd0 : rows_r;
    last_cur = WW'(col_cur) >= (width_eff - WW'(1));
    prod_cur = (rows_cur == 3'(STORED_LINES)) && (32'(col_cur) >= 32'(WIN - 1));
    if (last_cur) begin
      col_nxt  = '0;
      rows_nxt = (rows_cur < 3'(STORED_LINES)) ? rows_cur + 3'd1 : rows_cur;
    end else begin
      col_nxt  = col_cur + CW'(1);
      rows_nxt = rows_cur;
    end
  end

  assign gray_cur = GW'(in_beat.red_sample) * GW'(WEIGHT_R)
                  + GW'(in_beat.green_sample) * GW'(WEIGHT_G)
                  + GW'(in_beat.blue_sample) * GW'(WEIGHT_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      rows_r <= 3'd0;
    end else if (accept) begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
    end
  end

  // Line store: one word per column, six gray lines side by side, oldest low
  logic [MW-1:0] line_mem [MAX_WIDTH];
  logic [MW-1:0] rd_r, fwd_word_r, wr_word, rd_word;
  logic          fwd_hit_r;
  logic [CW-1:0] s1_col_r;
  logic [GW-1:0] s1_gray_r;
  logic [GW-1:0] column [WIN];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[col_cur];
    end
    if (s1_go) begin
      line_mem[s1_col_r] <= wr_word;
    end
  end

  // Same-column write in the accept cycle would be missed by the read: forward
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_hit_r  <= s1_go && (s1_col_r == col_cur);
      fwd_word_r <= wr_word;
      s1_col_r   <= col_cur;
      s1_gray_r  <= gray_cur;
      s1_last_r  <= last_cur;
      s1_prod_r  <= prod_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: assemble the column, write back shifted lines, shift the window
  // ---------------------------------------------------------------------------
  assign rd_word = fwd_hit_r ? fwd_word_r : rd_r;

  always_comb begin
    for (int k = 0; k < STORED_LINES; k++) begin
      column[k] = rd_word[k*GW +: GW];
    end
    column[WIN-1] = s1_gray_r;
    for (int k = 0; k < STORED_LINES; k++) begin
      wr_word[k*GW +: GW] = column[k+1];
    end
  end

  logic [GW-1:0] win_r [WIN][WIN];

  always_ff @(posedge clk) begin
    if (s1_go) begin
      for (int i = 0; i < WIN; i++) begin
        for (int c = 0; c < WIN - 1; c++) begin
          win_r[i][c] <= win_r[i][c+1];
        end
        win_r[i][WIN-1] <= column[i];
      end
      s2_last_r <= s1_last_r;
      s2_prod_r <= s1_prod_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: compare the ring taps against the center
  // ---------------------------------------------------------------------------
  logic [GW-1:0]       center, limit;
  logic [RING_PTS-1:0] hits, s3_hits_r;

  assign center = win_r[3][3];
  assign limit  = {threshold_r, GRAY_FRAC_BITS'(0)};

  always_comb begin
    for (int k = 0; k < RING_PTS; k++) begin
      if (win_r[RING_ROW[k]][RING_COL[k]] > center) begin
        hits[k] = (win_r[RING_ROW[k]][RING_COL[k]] - center) > limit;
      end else begin
        hits[k] = (center - win_r[RING_ROW[k]][RING_COL[k]]) > limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_prod_r) begin
      s3_hits_r <= hits;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: count and decide, then the output register
  // ---------------------------------------------------------------------------
  logic      is_corner;
  out_beat_t out_beat_r;

  assign is_corner = 5'($countones(s3_hits_r)) > min_count_r;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_beat_r.corner  <= is_corner;
      out_beat_r.shade   <= is_corner ? CORNER_SHADE : 8'd0;
      out_beat_r.row_end <= s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= accept;
      end
      if (s2_free) begin
        s2_vld_r <= s1_go;
      end
      if (s3_free) begin
        s3_vld_r <= s2_go & s2_prod_r;
      end
      if (out_free) begin
        out_vld_r <= s3_go;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire

[tb/tb_fast_corner_detector_ring16.sv]
// Self-checking testbench for the 16-point ring corner detector.
`timescale 1ns / 1ps

import fcd_pkg::*;

// Gray weights: 0.299 / 0.587 / 0.114 in fixed point, rounded to nearest
localparam int unsigned GRAY_W_RED   = (299 * (1 << GRAY_FRAC_BITS_DEF) + 500) / 1000;
localparam int unsigned GRAY_W_GREEN = (587 * (1 << GRAY_FRAC_BITS_DEF) + 500) / 1000;
localparam int unsigned GRAY_W_BLUE  = (114 * (1 << GRAY_FRAC_BITS_DEF) + 500) / 1000;

// Radius-3 ring as offsets from the window center, clockwise from the top
localparam int RING_DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
localparam int RING_DY [16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

// Mirror of the detector: line stores, window, counters and registers,
// plus the queue of corner verdicts still owed by the block.
class corner_scoreboard;
  bit [17:0]   line_mem [STORED_LINES][MAX_WIDTH_DEF];
  bit [17:0]   win_px [WIN][WIN];
  int unsigned col_count;
  int unsigned rows_done;
  bit [7:0]    thresh;
  bit [4:0]    min_hits;
  bit [10:0]   width_reg;
  out_beat_t   corner_verdicts [$];
  int unsigned errors;

  function new();
    thresh    = THRESHOLD_RST;
    min_hits  = MIN_COUNT_RST;
    width_reg = LINE_WIDTH_RST;
    col_count = 0;
    rows_done = 0;
    errors    = 0;
    foreach (line_mem[k, c]) line_mem[k][c] = '0;
    foreach (win_px[r, c]) win_px[r][c] = '0;
  endfunction

  function void load_register(cfg_reg_t idx, logic [31:0] value);
    case (idx)
      REG_THRESHOLD:  thresh    = value[7:0];
      REG_MIN_COUNT:  min_hits  = value[4:0];
      REG_LINE_WIDTH: width_reg = value[10:0];
      default: ;
    endcase
  endfunction

  // Note one accepted pixel and queue the verdict it causes, if any.
  function void predict_corner(in_beat_t px);
    bit [17:0]   col_px [WIN];
    int unsigned w, col, center, limit, hits, v, diff;
    bit          at_end, emit;
    out_beat_t   verdict;
    if (px.frame_start) begin
      col_count = 0;
      rows_done = 0;
    end
    w = width_reg;
    if (w < 7) w = 7;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    col = col_count;
    if (col >= MAX_WIDTH_DEF) col = MAX_WIDTH_DEF - 1;

    // Pull the column out of the line stores and push it up by one line
    for (int k = 0; k < STORED_LINES; k++) col_px[k] = line_mem[k][col];
    col_px[STORED_LINES] = 18'(GRAY_W_RED * px.red_sample + GRAY_W_GREEN * px.green_sample
                               + GRAY_W_BLUE * px.blue_sample);
    for (int k = 0; k < STORED_LINES; k++) line_mem[k][col] = col_px[k + 1];

    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c + 1];
      win_px[r][WIN - 1] = col_px[r];
    end

    at_end = (col >= w - 1);
    emit   = (rows_done >= STORED_LINES) && (col >= 6);
    if (at_end) begin
      col_count = 0;
      if (rows_done < STORED_LINES) rows_done++;
    end else begin
      col_count = col + 1;
    end

    if (emit) begin
      center = win_px[3][3];
      limit  = thresh;
      limit  = limit << GRAY_FRAC_BITS_DEF;
      hits   = 0;
      for (int k = 0; k < 16; k++) begin
        v    = win_px[3 + RING_DY[k]][3 + RING_DX[k]];
        diff = (v > center) ? v - center : center - v;
        if (diff > limit) hits++;
      end
      verdict.corner  = (hits > min_hits);
      verdict.shade   = verdict.corner ? CORNER_SHADE : 8'd0;
      verdict.row_end = at_end;
      corner_verdicts.push_back(verdict);
    end
  endfunction

  function void compare_result(out_beat_t got);
    out_beat_t want;
    if (corner_verdicts.size() == 0) begin
      $display("%0t: result with none expected, actual corner=%0b shade=%0d row_end=%0b",
               $time, got.corner, got.shade, got.row_end);
      errors++;
      return;
    end
    want = corner_verdicts.pop_front();
    if (got.corner !== want.corner) begin
      $display("%0t: corner mismatch, expected %0b, actual %0b", $time, want.corner, got.corner);
      errors++;
    end
    if (got.shade !== want.shade) begin
      $display("%0t: shade mismatch, expected %0d, actual %0d", $time, want.shade, got.shade);
      errors++;
    end
    if (got.row_end !== want.row_end) begin
      $display("%0t: row_end mismatch, expected %0b, actual %0b", $time, want.row_end,
               got.row_end);
      errors++;
    end
  endfunction
endclass

module tb_fast_corner_detector_ring16;

  localparam int unsigned RST_CYCLES   = 11;
  // Border pixels vanish silently inside the pipeline
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned ITEM_TARGET  = 1450;

  // Fixed settings walked after the directed frame: extremes of threshold and
  // min count, widths below the minimum, and a min count no ring can beat.
  localparam int unsigned N_FIXED      = 7;
  localparam int unsigned SHRINK_AFTER = 4;
  localparam bit [7:0]  FIX_THR   [N_FIXED] = '{8'd0, 8'd255, 8'd10, 8'd20, 8'd5, 8'd30, 8'd255};
  localparam bit [4:0]  FIX_MIN   [N_FIXED] = '{5'd0, 5'd16, 5'd16, 5'd31, 5'd8, 5'd6, 5'd0};
  localparam bit [10:0] FIX_WIDTH [N_FIXED] = '{11'd3, 11'd9, 11'd7, 11'd0, 11'd12, 11'd40,
                                                11'd16};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_beat_t    in_beat   = '0;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr  = '0;
  logic [31:0] pwdata    = '0;
  logic        in_stall;
  logic        out_valid;
  out_beat_t   out_beat;
  logic [31:0] prdata;
  logic        pready;

  corner_scoreboard corner_board = new();

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;
  int unsigned eff_width      = 640;

  fast_corner_detector_ring16 i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs on a handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: redraw the stall every clock at the phase's rate
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Check every result beat taken at this edge against the oldest verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) corner_board.compare_result(out_beat);
  end

  // Pick one of the four idle patterns; phases rotate through them.
  task automatic apply_idle(int unsigned phase);
    case (phase % 4)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
      default: begin send_gap_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // Offer one pixel beat, hold it through stalls, and note it once taken.
  task automatic push_pixel(in_beat_t px);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_beat  <= px;
    do @(posedge clk); while (in_stall);
    corner_board.predict_corner(px);
  endtask

  // Drop valid, release the output, and wait out every owed verdict plus the
  // pipeline depth so no border pixel is still in flight.
  task automatic drain();
    in_valid       <= 1'b0;
    recv_stall_pct = 0;
    while (corner_board.corner_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register (setup + access), then read it straight back.
  task automatic set_register(cfg_reg_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    corner_board.load_register(idx, value);
    if (idx == REG_LINE_WIDTH) begin
      eff_width = value[10:0];
      if (eff_width < 7) eff_width = 7;
      if (eff_width > MAX_WIDTH_DEF) eff_width = MAX_WIDTH_DEF;
    end
    // Read phase follows directly; psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: register %s readback, expected %0d, actual %0d", $time, idx.name(),
               value, prdata);
      corner_board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] jitter(logic [7:0] level);
    int v;
    v = int'(level) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Mostly a flat noisy background, with isolated spikes that light up the
  // whole ring, and some fully random pixels.
  function automatic in_beat_t scene_pixel(logic [23:0] bg);
    in_beat_t    px;
    int unsigned pick;
    px   = '0;
    pick = $urandom_range(99);
    if (pick < 70) begin
      px.red_sample   = jitter(bg[23:16]);
      px.green_sample = jitter(bg[15:8]);
      px.blue_sample  = jitter(bg[7:0]);
    end else if (pick < 85) begin
      px.red_sample   = bg[23] ? 8'd0 : 8'd255;
      px.green_sample = bg[15] ? 8'd0 : 8'd255;
      px.blue_sample  = bg[7]  ? 8'd0 : 8'd255;
    end else begin
      px.red_sample   = 8'($urandom_range(255));
      px.green_sample = 8'($urandom_range(255));
      px.blue_sample  = 8'($urandom_range(255));
    end
    return px;
  endfunction

  // Hand-placed 7-wide frame: black field, a white dot, a red line, and single
  // green and blue pixels, so each channel and both extremes reach the ring.
  function automatic in_beat_t probe_pixel(int unsigned row, int unsigned col);
    in_beat_t px;
    px = '0;
    px.frame_start = (row == 0) && (col == 0);
    if (row == 3 && col == 3) begin
      px.red_sample   = 8'd255;
      px.green_sample = 8'd255;
      px.blue_sample  = 8'd255;
    end else if (row == 5) begin
      px.red_sample = 8'd255;
    end else if (row == 6 && col == 2) begin
      px.green_sample = 8'd255;
    end else if (row == 6 && col == 4) begin
      px.blue_sample = 8'd255;
    end
    return px;
  endfunction

  // Stream a run of pixels; a fresh run opens with frame_start. A rare stray
  // frame_start mid-frame breaks the sequence and restarts the row count.
  task automatic run_frame(int unsigned count, bit fresh);
    logic [23:0] bg;
    in_beat_t    px;
    bg = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    for (int unsigned i = 0; i < count; i++) begin
      px = scene_pixel(bg);
      px.frame_start = (fresh && i == 0) || ($urandom_range(399) == 0);
      push_pixel(px);
    end
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned stream_items;
    int unsigned rows;
    int unsigned partial;
    int unsigned count;
    phase_no     = 0;
    stream_items = 0;

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame under the reset threshold and min count
    set_register(REG_LINE_WIDTH, 32'd7);
    apply_idle(phase_no++);
    for (int unsigned row = 0; row < 8; row++) begin
      for (int unsigned col = 0; col < 7; col++) push_pixel(probe_pixel(row, col));
    end
    stream_items += 8 * 7;
    drain();

    // Fixed settings, extremes first
    for (int unsigned i = 0; i < N_FIXED; i++) begin
      set_register(REG_THRESHOLD,  {24'd0, FIX_THR[i]});
      set_register(REG_MIN_COUNT,  {27'd0, FIX_MIN[i]});
      set_register(REG_LINE_WIDTH, {21'd0, FIX_WIDTH[i]});
      apply_idle(phase_no++);
      // Only seven rows at full width: enough to fill the stores and see one row
      rows    = (eff_width > 64) ? 7 : $urandom_range(8, 11);
      partial = (i == SHRINK_AFTER) ? 10 : $urandom_range(eff_width - 1);
      count   = rows * eff_width + partial;
      run_frame(count, 1'b1);
      stream_items += count;
      drain();
      if (i == SHRINK_AFTER) begin
        // Narrow the line while parked past the new last column: the next
        // pixel must close the line and the frame carries on without restart.
        set_register(REG_LINE_WIDTH, 32'd8);
        apply_idle(phase_no++);
        run_frame(8 * 5 + 3, 1'b0);
        stream_items += 8 * 5 + 3;
        drain();
      end
    end

    // Random settings until the stream target is met
    while (stream_items < ITEM_TARGET) begin
      set_register(REG_THRESHOLD,  $urandom_range(90));
      set_register(REG_MIN_COUNT,  $urandom_range(16));
      set_register(REG_LINE_WIDTH, $urandom_range(7, 24));
      apply_idle(phase_no++);
      count = $urandom_range(8, 12) * eff_width + $urandom_range(eff_width - 1);
      run_frame(count, 1'b1);
      stream_items += count;
      drain();
    end

    if (corner_board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[fast_corner_detector_ring16.f]
rtl/fcd_pkg.sv
rtl/fast_corner_detector_ring16.sv
tb/tb_fast_corner_detector_ring16.sv
